// ===== src/spc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the SPI controller with touch codec.
// No dependencies.
package spc_pkg;

  localparam int unsigned BufferWordsDefault = 64;
  localparam int unsigned NumChannels        = 3;
  localparam int unsigned ChanW              = $clog2(NumChannels);
  localparam int unsigned QueueDepth         = 2;
  localparam int unsigned QPtrW              = $clog2(QueueDepth);
  localparam int unsigned QCntW              = $clog2(QueueDepth + 1);

  localparam logic [31:0] PageMask  = 32'hFFFF_FF00;
  localparam logic [31:0] PageCh0   = 32'h1014_2800;
  localparam logic [31:0] PageCh1   = 32'h1014_3000;
  localparam logic [31:0] LenLimit  = 32'h0000_0100;
  localparam logic [31:0] PadWord   = 32'h0008_0008;
  localparam logic [31:0] CmdTouch  = 32'h0000_0003;
  localparam logic [15:0] CodedNone = 16'hFFFF;
  localparam int unsigned FillWords = 13;

  localparam logic [ChanW-1:0] Chan0 = ChanW'(0);
  localparam logic [ChanW-1:0] Chan1 = ChanW'(1);
  localparam logic [ChanW-1:0] Chan2 = ChanW'(2);

  localparam logic [5:0] RegControl = 6'd0;
  localparam logic [5:0] RegDone    = 6'd1;
  localparam logic [5:0] RegLength  = 6'd2;
  localparam logic [5:0] RegFifo    = 6'd3;

  // x * 4096 / 320 == (x * 64) / 5, y * 4096 / 240 == (y * 256) / 15
  localparam logic [15:0] RecipX = 16'd52429;
  localparam int unsigned ShiftX = 18;
  localparam logic [15:0] RecipY = 16'd34953;
  localparam int unsigned ShiftY = 19;

  typedef enum logic [1:0] {
    OP_READ      = 2'd0,
    OP_WRITE     = 2'd1,
    OP_TOUCH_SET = 2'd2,
    OP_TOUCH_REL = 2'd3
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [ChanW-1:0] chan;
    logic [5:0]       reg_idx;
    logic [31:0]      data;
    logic [15:0]      x_coded;
    logic [15:0]      y_coded;
  } entry_t;

  function automatic logic [15:0] swap16(input logic [15:0] v);
    swap16 = {v[7:0], v[15:8]};
  endfunction

  function automatic logic [31:0] fill_word(input logic [3:0] idx,
                                            input logic [15:0] x,
                                            input logic [15:0] y);
    unique case (idx)
      4'd0, 4'd1: fill_word = {x, x};
      4'd2:       fill_word = {y, x};
      4'd3, 4'd4: fill_word = {y, y};
      default:    fill_word = PadWord;
    endcase
  endfunction

endpackage

// ===== src/spc_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts a transaction, decodes channel and register, codes touch points.
// Depends on spc_pkg.
module spc_front (
  input  logic            start_i,
  input  logic            busy_i,
  input  logic [1:0]      operation_i,
  input  logic [31:0]     address_i,
  input  logic [31:0]     write_data_i,
  input  logic [8:0]      touch_x_i,
  input  logic [7:0]      touch_y_i,
  output logic            push_o,
  output spc_pkg::entry_t entry_o
);
  import spc_pkg::*;

  logic [14:0] x_scaled;
  logic [15:0] y_scaled;
  logic [30:0] x_prod;
  logic [31:0] y_prod;
  logic [12:0] x_quot;
  logic [12:0] y_quot;
  logic [31:0] page;

  assign push_o = start_i && !busy_i;

  assign page     = address_i & PageMask;
  assign x_scaled = {touch_x_i, 6'd0};
  assign y_scaled = {touch_y_i, 8'd0};
  assign x_prod   = 31'(x_scaled) * 31'(RecipX);
  assign y_prod   = 32'(y_scaled) * 32'(RecipY);
  assign x_quot   = x_prod[ShiftX +: 13];
  assign y_quot   = y_prod[ShiftY +: 13];

  always_comb begin
    entry_o.op      = op_e'(operation_i);
    entry_o.reg_idx = address_i[7:2];
    entry_o.data    = write_data_i;
    entry_o.x_coded = swap16({3'd0, x_quot});
    entry_o.y_coded = swap16({3'd0, y_quot});
    if (page == PageCh0) begin
      entry_o.chan = Chan0;
    end else if (page == PageCh1) begin
      entry_o.chan = Chan1;
    end else begin
      entry_o.chan = Chan2;
    end
  end

endmodule

// ===== src/spc_queue.sv =====
`timescale 1ns / 1ps
// Short FIFO of decoded transactions between front and back end.
// Depends on spc_pkg.
module spc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  spc_pkg::entry_t entry_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            valid_o,
  output spc_pkg::entry_t entry_o
);
  import spc_pkg::*;

  entry_t           mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (count_q == QCntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + QCntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && !valid_o))
    else $error("pop from empty queue");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + QCntW'(1)))
    else $error("queue count did not advance on push");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCntW'(QueueDepth))
    else $error("queue count out of range");

endmodule

// ===== src/spc_back.sv =====
`timescale 1ns / 1ps
// Back end: executes decoded transactions on channel state and registers the result.
// Depends on spc_pkg.
module spc_back #(
  parameter int unsigned BUFFER_WORDS = spc_pkg::BufferWordsDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  spc_pkg::entry_t entry_i,
  output logic            pop_o,
  output logic            done_o,
  output logic [31:0]     read_data_o,
  output logic            overflow_error_o
);
  import spc_pkg::*;

  localparam int unsigned PosW = $clog2(BUFFER_WORDS);

  logic [31:0]     len_q  [NumChannels];
  logic [31:0]     len_d  [NumChannels];
  logic [PosW-1:0] pos_q  [NumChannels];
  logic [PosW-1:0] pos_d  [NumChannels];
  logic            cmd_q  [NumChannels];
  logic            cmd_d  [NumChannels];
  logic [1:0]      dev0_q, dev0_d;
  logic            fill_q, fill_d;
  logic [15:0]     snap_x_q, snap_x_d;
  logic [15:0]     snap_y_q, snap_y_d;
  logic [15:0]     tx_q, tx_d;
  logic [15:0]     ty_q, ty_d;
  logic            done_q, done_d;
  logic [31:0]     rd_q, rd_d;
  logic            err_q, err_d;

  logic [31:0]     cur_len;
  logic [31:0]     nxt_len;
  logic [PosW-1:0] cur_pos;
  logic [PosW:0]   pos_inc;
  logic [PosW-1:0] adv_pos;
  logic [31:0]     fifo_word;

  assign pop_o   = valid_i;
  assign cur_len = len_q[entry_i.chan];
  assign cur_pos = pos_q[entry_i.chan];
  assign nxt_len = cur_len - 32'd4;
  assign pos_inc = {1'b0, cur_pos} + (PosW + 1)'(1);

  always_comb begin
    if (nxt_len == '0 || pos_inc >= (PosW + 1)'(BUFFER_WORDS)) begin
      adv_pos = '0;
    end else begin
      adv_pos = pos_inc[PosW-1:0];
    end
  end

  always_comb begin
    if (entry_i.chan == Chan0 && fill_q && cur_pos < PosW'(FillWords)) begin
      fifo_word = fill_word(cur_pos[3:0], snap_x_q, snap_y_q);
    end else begin
      fifo_word = '0;
    end
  end

  always_comb begin
    len_d    = len_q;
    pos_d    = pos_q;
    cmd_d    = cmd_q;
    dev0_d   = dev0_q;
    fill_d   = fill_q;
    snap_x_d = snap_x_q;
    snap_y_d = snap_y_q;
    tx_d     = tx_q;
    ty_d     = ty_q;
    done_d   = valid_i;
    rd_d     = '0;
    err_d    = 1'b0;
    if (valid_i) begin
      unique case (entry_i.op)
        OP_READ: begin
          if (entry_i.reg_idx == RegFifo) begin
            rd_d                = fifo_word;
            len_d[entry_i.chan] = nxt_len;
            pos_d[entry_i.chan] = adv_pos;
          end
        end
        OP_WRITE: begin
          unique case (entry_i.reg_idx)
            RegControl: begin
              if (entry_i.chan == Chan0) begin
                dev0_d = entry_i.data[7:6];
              end
            end
            RegDone: begin
              if (!entry_i.data[0]) begin
                cmd_d[entry_i.chan] = 1'b0;
              end
            end
            RegLength: begin
              len_d[entry_i.chan] = entry_i.data;
            end
            RegFifo: begin
              if (!cmd_q[entry_i.chan]) begin
                cmd_d[entry_i.chan] = (entry_i.data != '0);
                pos_d[entry_i.chan] = '0;
                if (entry_i.chan == Chan0) begin
                  fill_d   = (dev0_q == 2'd0) && (entry_i.data == CmdTouch);
                  snap_x_d = tx_q;
                  snap_y_d = ty_q;
                end
              end else if (cur_len >= LenLimit) begin
                err_d = 1'b1;
              end else begin
                len_d[entry_i.chan] = nxt_len;
                pos_d[entry_i.chan] = adv_pos;
              end
            end
            default: begin
            end
          endcase
        end
        OP_TOUCH_SET: begin
          tx_d = entry_i.x_coded;
          ty_d = entry_i.y_coded;
        end
        OP_TOUCH_REL: begin
          tx_d = CodedNone;
          ty_d = CodedNone;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumChannels; i++) begin
        len_q[i] <= '0;
        pos_q[i] <= '0;
        cmd_q[i] <= 1'b0;
      end
      dev0_q <= '0;
      fill_q <= 1'b0;
      tx_q   <= CodedNone;
      ty_q   <= CodedNone;
      done_q <= 1'b0;
    end else begin
      len_q  <= len_d;
      pos_q  <= pos_d;
      cmd_q  <= cmd_d;
      dev0_q <= dev0_d;
      fill_q <= fill_d;
      tx_q   <= tx_d;
      ty_q   <= ty_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    snap_x_q <= snap_x_d;
    snap_y_q <= snap_y_d;
    rd_q     <= rd_d;
    err_q    <= err_d;
  end

  assign done_o           = done_q;
  assign read_data_o      = rd_q;
  assign overflow_error_o = err_q;

endmodule

// ===== src/spi_controller_touch_codec.sv =====
`timescale 1ns / 1ps
// Top level of the three-channel SPI controller with touch and circle-pad codec.
// Depends on spc_pkg, spc_front, spc_queue, spc_back.
//
// A transaction is taken at a rising edge with start_i high and busy_o low; from the next
// rising edge its result is on read_data_o and overflow_error_o with done_o high for
// exactly one cycle, and must be captured at the edge that ends that cycle since the
// receiver cannot stall it. Every transaction gives exactly one result, in order. The
// back end executes one transaction per cycle and drains the two-entry queue as fast as
// the front fills it, so one transaction per cycle is sustained and busy_o stays low.
module spi_controller_touch_codec #(
  parameter int unsigned BUFFER_WORDS = spc_pkg::BufferWordsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  operation_i,
  input  logic [31:0] address_i,
  input  logic [31:0] write_data_i,
  input  logic [8:0]  touch_x_i,
  input  logic [7:0]  touch_y_i,
  output logic        done_o,
  output logic [31:0] read_data_o,
  output logic        overflow_error_o
);
  import spc_pkg::*;

  logic   push;
  logic   full;
  logic   q_valid;
  logic   pop;
  entry_t front_entry;
  entry_t back_entry;

  assign busy_o = full;

  spc_front u_front (
    .start_i      (start_i),
    .busy_i       (full),
    .operation_i  (operation_i),
    .address_i    (address_i),
    .write_data_i (write_data_i),
    .touch_x_i    (touch_x_i),
    .touch_y_i    (touch_y_i),
    .push_o       (push),
    .entry_o      (front_entry)
  );

  spc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (q_valid),
    .entry_o (back_entry)
  );

  spc_back #(
    .BUFFER_WORDS (BUFFER_WORDS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (q_valid),
    .entry_i          (back_entry),
    .pop_o            (pop),
    .done_o           (done_o),
    .read_data_o      (read_data_o),
    .overflow_error_o (overflow_error_o)
  );

endmodule
